// ===== sv/stereo_ssd_block_match_unit_macros.svh =====
// assertion macros included by the top-level rtl file
`ifndef STEREO_SSD_BLOCK_MATCH_UNIT_MACROS_SVH
`define STEREO_SSD_BLOCK_MATCH_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SSD_ASSERT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SSD_ASSERT(label, clk, rst_n, ante, cons, msg)
`define SSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/ssd_pkg.sv =====
package ssd_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DIV,
    S_PUSH
  } ssd_state_t;

  // control flags carried along the cell chain with each column
  typedef struct packed {
    logic valid;
    logic first_col;
    logic last_col;
    logic last_cand;
  } ssd_ctl_t;

  // configuration port
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 11;
  localparam logic [CFG_IW-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_IDX_NDISP  = 2'd2;

  localparam logic [10:0] RST_WIDTH  = 11'd722;
  localparam logic [10:0] RST_HEIGHT = 11'd480;
  localparam logic [8:0]  RST_NDISP  = 9'd190;

  // input item kinds
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  localparam int PIX_W = 8;
  localparam int SQ_W  = 16;

endpackage

// ===== sv/ssd_ram.sv =====
module ssd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/ssd_cell.sv =====
module ssd_cell #(
  parameter int COLW = 10,
  parameter int CW   = 22
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ssd_pkg::ssd_ctl_t         ctl_in,
  input  logic [COLW-1:0]           col_r_in,
  input  logic [COLW-1:0]           col_l_in,
  input  logic [CW-1:0]             psum_in,
  input  logic [ssd_pkg::PIX_W-1:0] pix_r,
  input  logic [ssd_pkg::PIX_W-1:0] pix_l,
  output ssd_pkg::ssd_ctl_t         ctl_out,
  output logic [COLW-1:0]           col_r_out,
  output logic [COLW-1:0]           col_l_out,
  output logic [CW-1:0]             psum_out,
  output ssd_pkg::ssd_ctl_t         meta_out
);

  ssd_pkg::ssd_ctl_t ctl_r, meta_r;
  logic [COLW-1:0]   col_r_r, col_l_r;
  logic [CW-1:0]     psum_r, psum_nxt;
  logic signed [ssd_pkg::PIX_W:0]     diff;
  logic signed [2*ssd_pkg::PIX_W+1:0] prod;

  // squared difference of this cell's row, added to the partial sum from upstream
  always_comb begin
    diff     = $signed({1'b0, pix_r}) - $signed({1'b0, pix_l});
    prod     = diff * diff;
    psum_nxt = psum_in + CW'(prod[ssd_pkg::SQ_W-1:0]);
  end

  // token and partial sum move one cell per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r  <= '0;
      meta_r <= '0;
    end else begin
      ctl_r  <= ctl_in;
      meta_r <= ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    col_r_r <= col_r_in;
    col_l_r <= col_l_in;
    psum_r  <= psum_nxt;
  end

  assign ctl_out   = ctl_r;
  assign col_r_out = col_r_r;
  assign col_l_out = col_l_r;
  assign psum_out  = psum_r;
  assign meta_out  = meta_r;

endmodule

// ===== sv/stereo_ssd_block_match_unit.sv =====
// An item that yields a result stalls the input until its result is pushed to the output register;
// when it has candidates, the sequencer first scans them through the cell chain, drains the chain
// and divides. Items without a result are taken without leaving idle. One item is in flight at a time.
// Reset: synchronous active-low rst_n clears control, counters and configuration registers to
// defaults; the datapath registers and the line memories are not cleared.
`include "stereo_ssd_block_match_unit_macros.svh"

module stereo_ssd_block_match_unit #(
  parameter int WINDOW_RADIUS   = 3,
  parameter int MAX_WIDTH       = 1024,
  parameter int MAX_HEIGHT      = 1024,
  parameter int MAX_DISPARITIES = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_func,
  input  logic [7:0]                       in_left_pixel,
  input  logic [7:0]                       in_right_pixel,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_depth_level,
  output logic [7:0]                       out_disparity_index,
  output logic                             out_last_pixel,
  input  logic                             cfg_we,
  input  logic [ssd_pkg::CFG_IW-1:0]       cfg_index,
  input  logic [ssd_pkg::CFG_DW-1:0]       cfg_data
);

  localparam int WIN   = 2 * WINDOW_RADIUS + 1;
  localparam int LINES = 2 * WINDOW_RADIUS + 2;
  localparam int LW    = $clog2(LINES);
  localparam int JW    = $clog2(WIN);
  localparam int COLW  = $clog2(MAX_WIDTH);
  localparam int ROWW  = $clog2(MAX_HEIGHT + WINDOW_RADIUS + 1);
  localparam int DW    = $clog2(MAX_DISPARITIES);
  localparam int NW    = $clog2(MAX_DISPARITIES + 1);
  localparam int CW    = $clog2(WIN * WIN * 65025 + 1);
  localparam int NUMW  = DW + 8;
  localparam int DCW   = $clog2(NUMW + 1);

  // configuration registers
  logic [10:0] cfg_width_r, cfg_height_r;
  logic [8:0]  cfg_ndisp_r;
  logic        cfg_hit;

  assign cfg_hit = cfg_we && (cfg_index == ssd_pkg::CFG_IDX_WIDTH ||
                              cfg_index == ssd_pkg::CFG_IDX_HEIGHT ||
                              cfg_index == ssd_pkg::CFG_IDX_NDISP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= ssd_pkg::RST_WIDTH;
      cfg_height_r <= ssd_pkg::RST_HEIGHT;
      cfg_ndisp_r  <= ssd_pkg::RST_NDISP;
    end else if (cfg_we) begin
      case (cfg_index)
        ssd_pkg::CFG_IDX_WIDTH:  cfg_width_r  <= cfg_data;
        ssd_pkg::CFG_IDX_HEIGHT: cfg_height_r <= cfg_data;
        ssd_pkg::CFG_IDX_NDISP:  cfg_ndisp_r  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // state
  ssd_pkg::ssd_state_t state_r, state_nxt;
  logic [ROWW-1:0] row_cnt_r, row_cnt_nxt;
  logic [COLW-1:0] col_cnt_r, col_cnt_nxt;
  logic [LW-1:0]   wr_row_r, wr_row_nxt;
  logic [COLW-1:0] x_r, x_nxt;
  logic [NW-1:0]   nc_r, nc_nxt;
  logic [LW-1:0]   base_r, base_nxt;
  logic            last_r, last_nxt;
  logic            found_r, found_nxt;
  logic [DW-1:0]   d_r, d_nxt;
  logic [JW-1:0]   j_r, j_nxt;
  logic [CW-1:0]   acc_r, acc_nxt;
  logic [CW-1:0]   best_cost_r, best_cost_nxt;
  logic [DW-1:0]   best_d_r, best_d_nxt;
  logic [DW:0]     cmp_d_r, cmp_d_nxt;
  logic [NW-1:0]   rem_r, rem_nxt;
  logic [NUMW-1:0] quo_r, quo_nxt;
  logic [NUMW-1:0] num_r, num_nxt;
  logic [DCW-1:0]  dcnt_r, dcnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_level_r, out_level_nxt;
  logic [7:0]      out_index_r, out_index_nxt;
  logic            out_last_r, out_last_nxt;

  // item decode against the frame counters
  logic            take, ignore_item, wr_en, emit, last_px, col_wrap;
  logic [NW-1:0]   n_eff, nc_v;
  logic [COLW-1:0] w_last;

  assign in_stall = (state_r != ssd_pkg::S_IDLE);
  assign take     = in_valid && !in_stall;

  always_comb begin
    int w_i, h_i, n_i, row_i, col_i, span_i, nc_i;
    logic in_frame, region;
    w_i = int'(cfg_width_r);
    if (w_i < 1) w_i = 1;
    if (w_i > MAX_WIDTH) w_i = MAX_WIDTH;
    h_i = int'(cfg_height_r);
    if (h_i < 1) h_i = 1;
    if (h_i > MAX_HEIGHT) h_i = MAX_HEIGHT;
    n_i = int'(cfg_ndisp_r);
    if (n_i > MAX_DISPARITIES) n_i = MAX_DISPARITIES;
    row_i = int'(row_cnt_r);
    col_i = int'(col_cnt_r);
    in_frame    = row_i < h_i;
    ignore_item = in_frame && (in_func == ssd_pkg::FUNC_FLUSH);
    wr_en       = take && in_frame && (in_func == ssd_pkg::FUNC_PIXEL);
    emit        = !ignore_item && (row_i >= WINDOW_RADIUS + 1);
    region      = (row_i >= WIN) && (row_i <= h_i) && (col_i >= WINDOW_RADIUS);
    span_i      = w_i - col_i - WINDOW_RADIUS;
    nc_i        = (span_i < n_i) ? span_i : n_i;
    if (!region || nc_i < 0) nc_i = 0;
    nc_v     = NW'(nc_i);
    n_eff    = NW'(n_i);
    last_px  = (row_i == h_i + WINDOW_RADIUS) && (col_i == w_i - 1);
    col_wrap = (col_i == w_i - 1);
    w_last   = COLW'(w_i - 1);
  end

  // cell chain wiring
  ssd_pkg::ssd_ctl_t ctl_c  [WIN+1];
  logic [COLW-1:0]   colr_c [WIN+1];
  logic [COLW-1:0]   coll_c [WIN+1];
  logic [CW-1:0]     psum_c [WIN+1];
  logic [7:0]        pixr_c [WIN];
  logic [7:0]        pixl_c [WIN];
  logic [LW-1:0]     pr     [WIN];
  ssd_pkg::ssd_ctl_t last_meta;

  // column token issued by the sequencer
  always_comb begin
    ctl_c[0].valid     = (state_r == ssd_pkg::S_SCAN);
    ctl_c[0].first_col = (j_r == '0);
    ctl_c[0].last_col  = (j_r == JW'(WIN - 1));
    ctl_c[0].last_cand = (j_r == JW'(WIN - 1)) && (NW'(d_r) + NW'(1) == nc_r);
    colr_c[0] = x_r - COLW'(WINDOW_RADIUS) + COLW'(j_r);
    coll_c[0] = colr_c[0] + COLW'(d_r);
    psum_c[0] = '0;
  end

  // physical line of each window row
  always_comb begin
    int t;
    for (int k = 0; k < WIN; k++) begin
      t = int'(base_r) + k;
      if (t >= LINES) t = t - LINES;
      pr[k] = LW'(t);
    end
  end

  // line memories, one pair per line
  logic [COLW-1:0] raddr_r_a [LINES];
  logic [COLW-1:0] raddr_l_a [LINES];
  logic [7:0]      rd_r_a    [LINES];
  logic [7:0]      rd_l_a    [LINES];

  always_comb begin
    for (int r = 0; r < LINES; r++) begin
      raddr_r_a[r] = '0;
      raddr_l_a[r] = '0;
      for (int k = 0; k < WIN; k++) begin
        if (pr[k] == LW'(r)) begin
          raddr_r_a[r] = colr_c[k];
          raddr_l_a[r] = coll_c[k];
        end
      end
    end
  end

  for (genvar r = 0; r < LINES; r++) begin : g_line
    ssd_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_right (
      .clk  (clk),
      .we   (wr_en && (wr_row_r == LW'(r))),
      .waddr(col_cnt_r),
      .wdata(in_right_pixel),
      .raddr(raddr_r_a[r]),
      .rdata(rd_r_a[r])
    );
    ssd_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_left (
      .clk  (clk),
      .we   (wr_en && (wr_row_r == LW'(r))),
      .waddr(col_cnt_r),
      .wdata(in_left_pixel),
      .raddr(raddr_l_a[r]),
      .rdata(rd_l_a[r])
    );
  end

  for (genvar k = 0; k < WIN; k++) begin : g_cell
    assign pixr_c[k] = rd_r_a[pr[k]];
    assign pixl_c[k] = rd_l_a[pr[k]];
    if (k == WIN - 1) begin : g_tail
      ssd_cell #(.COLW(COLW), .CW(CW)) u_cell (
        .clk(clk), .rst_n(rst_n),
        .ctl_in(ctl_c[k]), .col_r_in(colr_c[k]), .col_l_in(coll_c[k]),
        .psum_in(psum_c[k]), .pix_r(pixr_c[k]), .pix_l(pixl_c[k]),
        .ctl_out(ctl_c[k+1]), .col_r_out(colr_c[k+1]), .col_l_out(coll_c[k+1]),
        .psum_out(psum_c[k+1]), .meta_out(last_meta)
      );
    end else begin : g_body
      ssd_cell #(.COLW(COLW), .CW(CW)) u_cell (
        .clk(clk), .rst_n(rst_n),
        .ctl_in(ctl_c[k]), .col_r_in(colr_c[k]), .col_l_in(coll_c[k]),
        .psum_in(psum_c[k]), .pix_r(pixr_c[k]), .pix_l(pixl_c[k]),
        .ctl_out(ctl_c[k+1]), .col_r_out(colr_c[k+1]), .col_l_out(coll_c[k+1]),
        .psum_out(psum_c[k+1]), .meta_out()
      );
    end
  end

  // winner-take-all over the column sums leaving the chain
  logic            fin;
  logic [CW-1:0]   cost;
  logic [NW:0]     rem_sh;
  logic [NW:0]     two_rem;
  logic            round_up, push_load;

  assign fin  = last_meta.valid && last_meta.last_col && last_meta.last_cand;
  assign cost = last_meta.first_col ? psum_c[WIN] : acc_r + psum_c[WIN];

  always_comb begin
    acc_nxt       = acc_r;
    best_cost_nxt = best_cost_r;
    best_d_nxt    = best_d_r;
    cmp_d_nxt     = cmp_d_r;
    if (last_meta.valid) begin
      acc_nxt = cost;
      if (last_meta.last_col) begin
        if (cmp_d_r == '0 || cost < best_cost_r) begin
          best_cost_nxt = cost;
          best_d_nxt    = DW'(cmp_d_r);
        end
        cmp_d_nxt = cmp_d_r + 1'b1;
      end
    end
    if (take) begin
      cmp_d_nxt = '0;
    end
  end

  // divider step and rounding
  assign rem_sh    = {rem_r, num_r[NUMW-1]};
  assign two_rem   = {rem_r, 1'b0};
  assign round_up  = (two_rem > {1'b0, n_eff}) || ((two_rem == {1'b0, n_eff}) && quo_r[0]);
  assign push_load = (state_r == ssd_pkg::S_PUSH) && (!out_valid_r || !out_stall);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    row_cnt_nxt   = row_cnt_r;
    col_cnt_nxt   = col_cnt_r;
    wr_row_nxt    = wr_row_r;
    x_nxt         = x_r;
    nc_nxt        = nc_r;
    base_nxt      = base_r;
    last_nxt      = last_r;
    found_nxt     = found_r;
    d_nxt         = d_r;
    j_nxt         = j_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    num_nxt       = num_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_level_nxt = out_level_r;
    out_index_nxt = out_index_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ssd_pkg::S_IDLE: begin
        if (take && emit) begin
          x_nxt     = col_cnt_r;
          nc_nxt    = nc_v;
          base_nxt  = (wr_row_r == LW'(LINES - 1)) ? '0 : wr_row_r + 1'b1;
          last_nxt  = last_px;
          found_nxt = (nc_v != '0);
          d_nxt     = '0;
          j_nxt     = '0;
          state_nxt = (nc_v != '0) ? ssd_pkg::S_SCAN : ssd_pkg::S_PUSH;
        end
      end
      ssd_pkg::S_SCAN: begin
        if (j_r == JW'(WIN - 1)) begin
          j_nxt = '0;
          d_nxt = d_r + 1'b1;
          if (ctl_c[0].last_cand) begin
            state_nxt = ssd_pkg::S_DRAIN;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ssd_pkg::S_DRAIN: begin
        if (fin) begin
          num_nxt   = {best_d_nxt, 8'b0} - NUMW'(best_d_nxt);
          rem_nxt   = '0;
          quo_nxt   = '0;
          dcnt_nxt  = '0;
          state_nxt = ssd_pkg::S_DIV;
        end
      end
      ssd_pkg::S_DIV: begin
        num_nxt = {num_r[NUMW-2:0], 1'b0};
        if (rem_sh >= {1'b0, n_eff}) begin
          rem_nxt = NW'(rem_sh - {1'b0, n_eff});
          quo_nxt = {quo_r[NUMW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[NW-1:0];
          quo_nxt = {quo_r[NUMW-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DCW'(NUMW - 1)) begin
          state_nxt = ssd_pkg::S_PUSH;
        end
      end
      ssd_pkg::S_PUSH: begin
        if (push_load) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = found_r ? quo_r[7:0] + 8'(round_up) : 8'd0;
          out_index_nxt = found_r ? 8'(best_d_r) : 8'd0;
          out_last_nxt  = last_r;
          state_nxt     = ssd_pkg::S_IDLE;
        end
      end
      default: state_nxt = ssd_pkg::S_IDLE;
    endcase

    // frame position: restart on a register write, else advance per taken item other than an in-frame flush
    if (cfg_hit) begin
      row_cnt_nxt = '0;
      col_cnt_nxt = '0;
      wr_row_nxt  = '0;
    end else if (take && !ignore_item) begin
      if (emit && last_px) begin
        row_cnt_nxt = '0;
        col_cnt_nxt = '0;
        wr_row_nxt  = '0;
      end else if (col_wrap || col_cnt_r == w_last) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = row_cnt_r + 1'b1;
        wr_row_nxt  = (wr_row_r == LW'(LINES - 1)) ? '0 : wr_row_r + 1'b1;
      end else begin
        col_cnt_nxt = col_cnt_r + 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssd_pkg::S_IDLE;
      row_cnt_r   <= '0;
      col_cnt_r   <= '0;
      wr_row_r    <= '0;
      out_valid_r <= 1'b0;
      cmp_d_r     <= '0;
      d_r         <= '0;
      j_r         <= '0;
      dcnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      row_cnt_r   <= row_cnt_nxt;
      col_cnt_r   <= col_cnt_nxt;
      wr_row_r    <= wr_row_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_d_r     <= cmp_d_nxt;
      d_r         <= d_nxt;
      j_r         <= j_nxt;
      dcnt_r      <= dcnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    nc_r        <= nc_nxt;
    base_r      <= base_nxt;
    last_r      <= last_nxt;
    found_r     <= found_nxt;
    acc_r       <= acc_nxt;
    best_cost_r <= best_cost_nxt;
    best_d_r    <= best_d_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    num_r       <= num_nxt;
    out_level_r <= out_level_nxt;
    out_index_r <= out_index_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_depth_level     = out_level_r;
  assign out_disparity_index = out_index_r;
  assign out_last_pixel      = out_last_r;

  // checks
  `SSD_ASSERT_NEXT(a_fin_to_div, clk, rst_n, fin, state_r == ssd_pkg::S_DIV, "search end missed")
  `SSD_ASSERT(a_idle_empty, clk, rst_n, state_r == ssd_pkg::S_IDLE, !last_meta.valid, "chain busy in idle")
  `SSD_ASSERT_NEXT(a_scan_next, clk, rst_n, state_r == ssd_pkg::S_SCAN, state_r == ssd_pkg::S_SCAN || state_r == ssd_pkg::S_DRAIN, "bad scan exit")
  `SSD_ASSERT_NEXT(a_push_load, clk, rst_n, push_load, out_valid_r, "result not loaded")

endmodule
